FILE: sv/mdds_pkg.sv
// ----------------------------------------------------------------------------
// mdds_pkg: shared types and constants of the display scanner
// Field widths, reset values, register indexes and the request that
// starts one serial digit extraction.
// ----------------------------------------------------------------------------
`default_nettype none

package mdds_pkg;

	localparam int VALUE_W    = 32;              // held number width
	localparam int POW_W      = 24;              // power-of-ten register width
	localparam int TICK_W     = 16;              // elapsed / interval width
	localparam int COUNT_W    = 4;               // digit_count register width
	localparam int LINES      = 8;               // digit enable lines
	localparam int POS_W      = 3;               // digit_position field width
	localparam int BCD_W      = 4;
	localparam int STEP_W     = $clog2(VALUE_W); // serial step counter width
	localparam int CFG_IDX_W  = 2;

	localparam int SCAN_DIGITS_DEF = 8;
	localparam int RADIX           = 10;

	localparam logic [TICK_W-1:0]  INTERVAL_RST = 16'd1000;
	localparam logic [COUNT_W-1:0] COUNT_RST    = 4'd4;
	localparam logic               LEVEL_RST    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL = 2'd0,
		REG_COUNT    = 2'd1,
		REG_LEVEL    = 2'd2
	} cfg_reg_t;

	// Request to the serial digit extractor.
	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [POW_W-1:0]   divisor;
	} dig_req_t;

endpackage

`default_nettype wire

FILE: sv/mdds_digit.sv
// ----------------------------------------------------------------------------
// mdds_digit: bit-serial decimal digit extractor
// Computes (dividend / divisor) % 10 with a restoring divider that retires
// one quotient bit per cycle, folding each bit into a running mod-10 value.
// ----------------------------------------------------------------------------
`default_nettype none

module mdds_digit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mdds_pkg::dig_req_t          req,
	output logic                             busy,
	output logic [mdds_pkg::BCD_W-1:0]       digit
);

	localparam int VW = mdds_pkg::VALUE_W;
	localparam int PW = mdds_pkg::POW_W;
	localparam int SW = mdds_pkg::STEP_W;
	localparam int BW = mdds_pkg::BCD_W;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t          state_q;
	logic [SW-1:0]   step_q;
	logic [VW-1:0]   num_q;
	logic [PW-1:0]   div_q;
	logic [PW-1:0]   rem_q;
	logic [BW-1:0]   digit_q;

	logic [PW:0]     shifted;
	logic            qbit;
	logic [PW-1:0]   rem_n;
	logic [BW:0]     mod2;
	logic [BW-1:0]   digit_n;

	always_comb begin
		shifted = {rem_q, num_q[VW-1]};
		qbit    = (shifted >= {1'b0, div_q});
		rem_n   = qbit ? PW'(shifted - {1'b0, div_q}) : shifted[PW-1:0];
		// running quotient mod 10: r = (2r + bit) mod 10
		mod2    = {digit_q, qbit};
		digit_n = (mod2 >= (BW+1)'(mdds_pkg::RADIX))
			? BW'(mod2 - (BW+1)'(mdds_pkg::RADIX)) : mod2[BW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			num_q   <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			digit_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						num_q   <= req.dividend;
						div_q   <= req.divisor;
						rem_q   <= '0;
						digit_q <= '0;
						step_q  <= SW'(VW - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					num_q   <= {num_q[VW-2:0], 1'b0};
					rem_q   <= rem_n;
					digit_q <= digit_n;
					if (step_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy  = (state_q == ST_RUN);
	assign digit = digit_q;

endmodule

`default_nettype wire

FILE: sv/multiplexed_decimal_display_scan.sv
// ----------------------------------------------------------------------------
// multiplexed_decimal_display_scan: multiplexed decimal display scanner
// Lights one digit at a time and presents its decimal value as BCD.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item:
//   kind = 0 is one time tick, kind = 1 loads value as the held number.
//   Every input transaction yields exactly one output transaction
//   (out_valid / out_stall) with the digit enables, the latched BCD digit,
//   the lit position and a readback of the held number.
//   A write or a tick that does not switch digits moves into the output
//   register as soon as it is free. A tick that switches digits first
//   runs the serial extractor, one quotient bit per cycle over 32 bits,
//   before its result moves into the output register. One item is in
//   flight at a time: in_stall stays high from acceptance until the result
//   moves into the output register, so a new item is taken only once the
//   last one is through. The user writes configuration (cfg_valid /
//   cfg_ready, always ready) only while idle; the block does not enforce it.
//   Reset: interval 1000, 4 digits, active-high enables, digit 0 lit,
//   held number 0, BCD 0, no output pending.
//   A stalled receiver holds the output register; one more transaction is
//   taken and its result held behind it, with in_stall high until it frees.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_decimal_display_scan #(
	parameter int SCAN_DIGITS = mdds_pkg::SCAN_DIGITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              kind,
	input  wire logic [mdds_pkg::VALUE_W-1:0]      value,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mdds_pkg::LINES-1:0]             digit_enable,
	output logic [mdds_pkg::BCD_W-1:0]             bcd_digit,
	output logic [mdds_pkg::POS_W-1:0]             digit_position,
	output logic [mdds_pkg::VALUE_W-1:0]           stored_number,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mdds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mdds_pkg::TICK_W-1:0]       cfg_data
);

	localparam int IDX_W = (SCAN_DIGITS > 1) ? $clog2(SCAN_DIGITS) : 1;
	localparam int VW    = mdds_pkg::VALUE_W;
	localparam int PW    = mdds_pkg::POW_W;
	localparam int TW    = mdds_pkg::TICK_W;
	localparam int CW    = mdds_pkg::COUNT_W;
	localparam int NL    = mdds_pkg::LINES;

	// configuration registers
	logic [TW-1:0]    interval_q;
	logic [CW-1:0]    count_q;
	logic             level_q;

	// scan state
	logic [TW-1:0]    elapsed_q;
	logic [IDX_W-1:0] index_q;
	logic [PW-1:0]    power_q;
	logic [VW-1:0]    held_q;
	logic             pend_q;

	// output register
	logic             out_valid_q;
	logic [NL-1:0]    enable_q;
	logic [mdds_pkg::BCD_W-1:0] bcd_q;
	logic [mdds_pkg::POS_W-1:0] pos_q;
	logic [VW-1:0]    number_q;

	logic             in_take;
	logic             cfg_take;
	logic [TW-1:0]    elapsed_inc;
	logic             advance;
	logic [IDX_W:0]   index_inc;
	logic             wrap;
	logic [IDX_W-1:0] index_n;
	logic [PW-1:0]    power_n;
	logic             dig_busy;
	logic [mdds_pkg::BCD_W-1:0] dig_digit;
	logic             load_out;
	logic [NL-1:0]    enable_n;
	logic [CW-1:0]    cfg_count;
	mdds_pkg::dig_req_t dig_req;

	assign in_stall  = pend_q;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign cfg_count = cfg_data[CW-1:0];

	// Tick handling: saturating counter, advance once the interval is met.
	always_comb begin
		elapsed_inc = (elapsed_q == {TW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
		advance     = in_take && !kind && (elapsed_inc >= interval_q);
		index_inc   = {1'b0, index_q} + 1'b1;
		wrap        = ((CW+IDX_W+1)'(index_inc) >= (CW+IDX_W+1)'(count_q));
		index_n     = wrap ? '0 : index_inc[IDX_W-1:0];
		// times ten as shift-and-add, truncated to the register width
		power_n     = wrap ? PW'(1) : PW'({power_q, 3'b000} + {power_q, 1'b0});
	end

	// Start the extractor on a digit switch; a zero power reads as one.
	always_comb begin
		dig_req.start    = advance;
		dig_req.dividend = held_q;
		dig_req.divisor  = (power_n == '0) ? PW'(1) : power_n;
	end

	mdds_digit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dig_req),
		.busy   (dig_busy),
		.digit  (dig_digit)
	);

	// Enable lines: the lit digit at the active level, all others off.
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			enable_n[k] = ((CW+IDX_W)'(k) < (CW+IDX_W)'(count_q)) &&
				((CW+IDX_W)'(k) == (CW+IDX_W)'(index_q)) ? level_q : !level_q;
		end
	end

	// Move the finished result into the output register when it is free.
	assign load_out = pend_q && !dig_busy && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= mdds_pkg::INTERVAL_RST;
			count_q    <= mdds_pkg::COUNT_RST;
			level_q    <= mdds_pkg::LEVEL_RST;
		end else if (cfg_take) begin
			case (mdds_pkg::cfg_reg_t'(cfg_index))
				mdds_pkg::REG_INTERVAL: begin
					interval_q <= cfg_data;
				end
				mdds_pkg::REG_COUNT: begin
					// drop counts outside 1..SCAN_DIGITS
					if (cfg_count != '0 && cfg_count <= CW'(SCAN_DIGITS)) begin
						count_q <= cfg_count;
					end
				end
				mdds_pkg::REG_LEVEL: begin
					level_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			index_q   <= '0;
			power_q   <= PW'(1);
			held_q    <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (in_take) begin
				pend_q <= 1'b1;
				if (kind) begin
					held_q <= value;
				end else if (advance) begin
					elapsed_q <= '0;
					index_q   <= index_n;
					power_q   <= power_n;
				end else begin
					elapsed_q <= elapsed_inc;
				end
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			enable_q    <= '0;
			bcd_q       <= '0;
			pos_q       <= '0;
			number_q    <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			enable_q    <= enable_n;
			bcd_q       <= dig_digit;
			pos_q       <= mdds_pkg::POS_W'(index_q);
			number_q    <= held_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign digit_enable   = enable_q;
	assign bcd_digit      = bcd_q;
	assign digit_position = pos_q;
	assign stored_number  = number_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multiplexed decimal display scanner
// Drives ticks and number writes, programs the three scan registers while
// the block is idle, and checks every output transaction field by field
// against a cycle-free model of the scan state kept in this file.
// ----------------------------------------------------------------------------

module testbench;
	import mdds_pkg::*;

	// Item kinds on the input channel.
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Register index with no register behind it; a write there must be a no-op.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Cycles to let pass once nothing is outstanding: one full digit extraction
	// plus margin.
	localparam int SETTLE_CYCLES = 40;

	// Idle and stall chances in percent, one entry per random phase.
	localparam int IDLE_BY_PHASE[4]  = '{0, 84, 0, 23};
	localparam int STALL_BY_PHASE[4] = '{0, 0, 84, 23};

	typedef struct packed {
		logic [LINES-1:0]   enables;
		logic [BCD_W-1:0]   bcd;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] number;
	} scan_result_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_WRITE, ROW_REG} row_op_t;

	// One row of the directed table: an input item or a register write.
	// Rows with has_want set carry a hand-written expectation.
	typedef struct packed {
		row_op_t              op;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [VALUE_W-1:0]   data;
		logic                 has_want;
		scan_result_t         want;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	logic [VALUE_W-1:0]   value;
	logic                 out_valid;
	logic                 out_stall;
	logic [LINES-1:0]     digit_enable;
	logic [BCD_W-1:0]     bcd_digit;
	logic [POS_W-1:0]     digit_position;
	logic [VALUE_W-1:0]   stored_number;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	// Scan registers as the model sees them.
	logic [TICK_W-1:0]    dwell_ticks;
	logic [COUNT_W-1:0]   scan_width;
	logic                 on_level;

	// Scan state as the model sees it.
	logic [TICK_W-1:0]    lit_ticks;
	logic [POS_W-1:0]     lit_digit;
	logic [POW_W-1:0]     place_value;
	logic [VALUE_W-1:0]   shown_number;
	logic [BCD_W-1:0]     latched_bcd;

	scan_result_t  pending_scans[$];
	directed_row_t directed_rows[$];

	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	multiplexed_decimal_display_scan uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_enable   (digit_enable),
		.bcd_digit      (bcd_digit),
		.digit_position (digit_position),
		.stored_number  (stored_number),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a transaction never completes.
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// --------------------------------------------------------------------
	// Model of the scanner
	// --------------------------------------------------------------------

	function automatic void reset_scan_model();
		dwell_ticks  = INTERVAL_RST;
		scan_width   = COUNT_RST;
		on_level     = LEVEL_RST;
		lit_ticks    = '0;
		lit_digit    = '0;
		place_value  = POW_W'(1);
		shown_number = '0;
		latched_bcd  = '0;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] data);
		case (idx)
			REG_INTERVAL: dwell_ticks = data;
			// Only 1..SCAN_DIGITS counts take effect; the rest are dropped.
			REG_COUNT: begin
				if (data[COUNT_W-1:0] >= 1 && data[COUNT_W-1:0] <= SCAN_DIGITS_DEF)
					scan_width = data[COUNT_W-1:0];
			end
			REG_LEVEL: on_level = data[0];
			default: ;
		endcase
	endfunction

	// Advance the model by one input item and return the output it causes.
	function automatic scan_result_t predict_scan(input logic k,
			input logic [VALUE_W-1:0] v);
		scan_result_t r;
		int unsigned  next_digit;
		logic [31:0]  widened;
		logic [31:0]  divisor;
		logic [31:0]  digit;
		if (k == KIND_WRITE) begin
			// The number is read back at once; the BCD lines wait for a switch.
			shown_number = v;
		end else begin
			// Saturate rather than wrap; a full counter always meets the interval.
			if (lit_ticks != {TICK_W{1'b1}})
				lit_ticks = lit_ticks + 1'b1;
			if (lit_ticks >= dwell_ticks) begin
				lit_ticks   = '0;
				widened     = {8'd0, place_value} * 32'd10;
				place_value = widened[POW_W-1:0];
				next_digit  = lit_digit + 1;
				// Wrap after the last scanned digit, also when the count was
				// lowered below the lit digit.
				if (next_digit >= scan_width) begin
					lit_digit   = '0;
					place_value = POW_W'(1);
				end else begin
					lit_digit = next_digit[POS_W-1:0];
				end
				divisor     = (place_value == '0) ? 32'd1 : {8'd0, place_value};
				digit       = (shown_number / divisor) % 32'd10;
				latched_bcd = digit[BCD_W-1:0];
			end
		end
		// Lit line at the active level, every other line (and all lines past
		// the count) at the off level.
		for (int i = 0; i < LINES; i++)
			r.enables[i] = (i < scan_width && i == lit_digit) ? on_level : ~on_level;
		r.bcd      = latched_bcd;
		r.position = lit_digit;
		r.number   = shown_number;
		return r;
	endfunction

	// --------------------------------------------------------------------
	// Directed table helpers
	// --------------------------------------------------------------------

	function automatic directed_row_t checked_row(input row_op_t op,
			input logic [VALUE_W-1:0] data, input scan_result_t want);
		return '{op, REG_INTERVAL, data, 1'b1, want};
	endfunction

	function automatic directed_row_t free_row(input row_op_t op,
			input logic [VALUE_W-1:0] data);
		return '{op, REG_INTERVAL, data, 1'b0, '0};
	endfunction

	function automatic directed_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] data);
		return '{ROW_REG, idx, {16'd0, data}, 1'b0, '0};
	endfunction

	// --------------------------------------------------------------------
	// Transaction tasks
	// --------------------------------------------------------------------

	// Offer one input item, idling first at random, and hold it until the
	// block takes it. Queue the expectation on the accepting edge.
	task automatic feed_item(input logic k, input logic [VALUE_W-1:0] v,
			input logic has_want, input scan_result_t want);
		scan_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind     = k;
		value    = v;
		do @(posedge clk); while (in_stall);
		predicted = predict_scan(k, v);
		pending_scans.push_back(has_want ? want : predicted);
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Numbers that exercise all places: full range, short, near the top, 8 digits.
	function automatic logic [VALUE_W-1:0] pick_number();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $urandom_range(0, 999);
			2:       return 32'hFFFF_FFFF - $urandom_range(0, 99);
			default: return $urandom % 100_000_000;
		endcase
	endfunction

	// Program a fresh scan setting. Full-width writes toggle every data bit;
	// the follow-up writes leave a short interval and a valid count in place.
	task automatic shuffle_setting();
		write_reg(REG_INTERVAL, TICK_W'($urandom_range(0, 16'hFFFF)));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_INTERVAL, TICK_W'($urandom_range(5, 20)));
		else
			write_reg(REG_INTERVAL, TICK_W'($urandom_range(0, 4)));
		write_reg(REG_COUNT, TICK_W'($urandom_range(0, 16'hFFFF)));
		write_reg(REG_COUNT, TICK_W'($urandom_range(1, SCAN_DIGITS_DEF)));
		write_reg(REG_LEVEL, TICK_W'($urandom_range(0, 16'hFFFF)));
	endtask

	// --------------------------------------------------------------------
	// Output side
	// --------------------------------------------------------------------

	function automatic void note_error(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what,
				want, got);
	endfunction

	// Randomize the receiver stall on every falling edge.
	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < stall_pct);
	end

	// Compare each output transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scans.size() == 0) begin
				note_error("unexpected result", '0, stored_number);
			end else begin
				want = pending_scans.pop_front();
				if (digit_enable !== want.enables)
					note_error("digit_enable", 32'(want.enables), 32'(digit_enable));
				if (bcd_digit !== want.bcd)
					note_error("bcd_digit", 32'(want.bcd), 32'(bcd_digit));
				if (digit_position !== want.position)
					note_error("digit_position", 32'(want.position),
						32'(digit_position));
				if (stored_number !== want.number)
					note_error("stored_number", want.number, stored_number);
			end
		end
	end

	// --------------------------------------------------------------------
	// Stimulus
	// --------------------------------------------------------------------

	initial begin
		in_valid  = 1'b0;
		kind      = KIND_TICK;
		value     = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_INTERVAL;
		cfg_data  = '0;
		arst_n    = 1'b0;
		reset_scan_model();

		// Walk digits of all-ones with a zero interval, flip the level, run
		// eight digits, then lower the count under the lit digit and try
		// count and index values the block must ignore.
		directed_rows = '{
			checked_row(ROW_TICK,  32'hDEAD_BEEF, '{8'h01, 4'd0, 3'd0, 32'd0}),
			checked_row(ROW_WRITE, 32'hFFFF_FFFF, '{8'h01, 4'd0, 3'd0, 32'hFFFF_FFFF}),
			reg_row(REG_INTERVAL, 16'd0),
			checked_row(ROW_TICK,  32'd0, '{8'h02, 4'd9, 3'd1, 32'hFFFF_FFFF}),
			checked_row(ROW_TICK,  32'd0, '{8'h04, 4'd2, 3'd2, 32'hFFFF_FFFF}),
			checked_row(ROW_TICK,  32'd0, '{8'h08, 4'd7, 3'd3, 32'hFFFF_FFFF}),
			checked_row(ROW_TICK,  32'd0, '{8'h01, 4'd5, 3'd0, 32'hFFFF_FFFF}),
			reg_row(REG_LEVEL, 16'd0),
			checked_row(ROW_TICK,  32'd0, '{8'hFD, 4'd9, 3'd1, 32'hFFFF_FFFF}),
			reg_row(REG_COUNT, 16'd8),
			checked_row(ROW_WRITE, 32'd0, '{8'hFD, 4'd9, 3'd1, 32'd0}),
			free_row(ROW_WRITE, 32'd87654321),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'd0),
			reg_row(REG_COUNT, 16'd2),
			checked_row(ROW_WRITE, 32'd99, '{8'hFF, 4'd8, 3'd7, 32'd99}),
			checked_row(ROW_TICK,  32'd0, '{8'hFE, 4'd9, 3'd0, 32'd99}),
			reg_row(REG_COUNT, 16'd0),
			reg_row(REG_COUNT, 16'd9),
			reg_row(REG_SPARE, 16'd5),
			checked_row(ROW_TICK,  32'd0, '{8'hFD, 4'd9, 3'd1, 32'd99}),
			checked_row(ROW_TICK,  32'd0, '{8'hFE, 4'd9, 3'd0, 32'd99}),
			reg_row(REG_LEVEL, 16'd1),
			reg_row(REG_INTERVAL, 16'd3),
			free_row(ROW_WRITE, 32'd4_000_000_000),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'd0),
			free_row(ROW_TICK, 32'hFFFF_FFFF),
			reg_row(REG_COUNT, 16'hFF13),
			reg_row(REG_INTERVAL, 16'hFFFF)
		};

		// Hold reset, then release it away from the sampling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, no idling on either side.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_REG) begin
				drain_results();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].data[TICK_W-1:0]);
			end else begin
				feed_item((directed_rows[i].op == ROW_WRITE) ? KIND_WRITE : KIND_TICK,
					directed_rows[i].data, directed_rows[i].has_want,
					directed_rows[i].want);
			end
		end

		// Random part: four idling phases, two settings each, with an
		// occasional full drain so the sender waits on every result.
		for (int phase = 0; phase < 4; phase++) begin
			for (int half = 0; half < 2; half++) begin
				drain_results();
				idle_pct  = IDLE_BY_PHASE[phase];
				stall_pct = STALL_BY_PHASE[phase];
				shuffle_setting();
				for (int n = 0; n < 56; n++) begin
					if ($urandom_range(0, 49) == 0)
						drain_results();
					if ($urandom_range(0, 3) == 0)
						feed_item(KIND_WRITE, pick_number(), 1'b0, '0);
					else
						feed_item(KIND_TICK, $urandom, 1'b0, '0);
				end
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
